/* rtl/core/sorted_table_binary_search_defines.svh */
// ----------------------------------------------------------------------------
// sorted_table_binary_search_defines.svh
// Assertion macros used by the checker file of the search block.
// ----------------------------------------------------------------------------
`ifndef SORTED_TABLE_BINARY_SEARCH_DEFINES_SVH
`define SORTED_TABLE_BINARY_SEARCH_DEFINES_SVH

// Same-cycle implication, disabled while reset is low.
`define STBS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("stbs assertion failed");

// Next-cycle implication, disabled while reset is low.
`define STBS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("stbs assertion failed");

`endif

/* rtl/core/stbs_pkg.sv */
// ----------------------------------------------------------------------------
// stbs_pkg
// Types, constants and command/status groups of the sorted table search.
// ----------------------------------------------------------------------------
`default_nettype none

package stbs_pkg;

    localparam int TABLE_DEPTH = 1024;
    localparam int IDX_W       = 10;
    localparam int COORD_W     = 32;

    localparam logic KIND_LOAD  = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    typedef struct packed {
        logic                      kind;
        logic [IDX_W-1:0]          write_index;
        logic signed [COORD_W-1:0] entry_coord;
        logic signed [COORD_W-1:0] search_value;
        logic [IDX_W-1:0]          range_start;
        logic [IDX_W-1:0]          range_stop;
    } stbs_req_t;

    typedef struct packed {
        logic             found;
        logic [IDX_W-1:0] match_index;
    } stbs_rsp_t;

    // Read address source of the table
    typedef enum logic [1:0] {
        ADDR_LO,
        ADDR_HI,
        ADDR_MID_FIRST,
        ADDR_MID_NEXT
    } stbs_addr_e;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_RD_HI,
        S_BOUND,
        S_BISECT,
        S_FINISH,
        S_MISS
    } stbs_state_e;

    // Controller to datapath
    typedef struct packed {
        logic       take;
        stbs_addr_e addr_sel;
        logic       cap_lo;
        logic       bound_step;
        logic       bisect_step;
        logic       res_we;
        logic       res_miss;
    } stbs_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic range_ok;
        logic bound_ok;
        logic wide;
        logic cont;
        logic res_free;
    } stbs_sts_t;

endpackage

`default_nettype wire

/* rtl/core/stbs_dpath.sv */
// ----------------------------------------------------------------------------
// stbs_dpath
// Coordinate table, bisection bounds and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module stbs_dpath (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire stbs_pkg::stbs_req_t req,
    input  wire stbs_pkg::stbs_cmd_t cmd,
    output stbs_pkg::stbs_sts_t    sts,
    output logic                   rsp_valid,
    input  wire logic              rsp_stall,
    output stbs_pkg::stbs_rsp_t    rsp
);
    import stbs_pkg::*;

    logic signed [COORD_W-1:0] coord_table [TABLE_DEPTH];
    logic signed [COORD_W-1:0] rd_data_reg;
    logic [IDX_W-1:0]          rd_addr;
    logic                      tbl_we;

    logic [IDX_W-1:0]          lo_reg, hi_reg, mid_reg;
    logic signed [COORD_W-1:0] key_reg, elo_reg, ehi_reg;

    logic                      rsp_valid_reg, rsp_valid_next;
    stbs_rsp_t                 rsp_reg;

    logic [IDX_W-1:0]          span, d_lo, d_hi;
    logic [IDX_W-1:0]          mid_first, mid_go_lo, mid_go_hi, mid_next;
    logic                      mid_gt;
    logic                      hit_lo, hit_hi;

    // Bisection arithmetic
    assign span      = hi_reg - lo_reg;
    assign mid_first = lo_reg + (span >> 1);
    assign d_lo      = mid_reg - lo_reg;
    assign d_hi      = hi_reg - mid_reg;
    assign mid_go_lo = lo_reg + (d_lo >> 1);
    assign mid_go_hi = mid_reg + (d_hi >> 1);
    assign mid_gt    = rd_data_reg > key_reg;
    assign mid_next  = mid_gt ? mid_go_lo : mid_go_hi;

    // Table read address
    always_comb
    begin
        unique case (cmd.addr_sel)
            ADDR_LO:        rd_addr = lo_reg;
            ADDR_HI:        rd_addr = hi_reg;
            ADDR_MID_FIRST: rd_addr = mid_first;
            ADDR_MID_NEXT:  rd_addr = mid_next;
            default:        rd_addr = lo_reg;
        endcase
    end

    // Status toward the controller
    assign sts.range_ok = (hi_reg >= lo_reg) &&
                          ({1'b0, hi_reg} < (IDX_W+1)'(TABLE_DEPTH));
    assign sts.bound_ok = (key_reg >= elo_reg) && (key_reg <= rd_data_reg);
    assign sts.wide     = span > IDX_W'(1);
    assign sts.cont     = mid_gt ? (d_lo > IDX_W'(1)) : (d_hi > IDX_W'(1));
    assign sts.res_free = !rsp_valid_reg || !rsp_stall;

    // Table: one write and one registered read per cycle
    assign tbl_we = cmd.take && (req.kind == KIND_LOAD) &&
                    ({1'b0, req.write_index} < (IDX_W+1)'(TABLE_DEPTH));

    always_ff @(posedge clk)
    begin
        if (tbl_we)
        begin
            coord_table[req.write_index] <= req.entry_coord;
        end
        rd_data_reg <= coord_table[rd_addr];
    end

    // Query bounds and end entries
    always_ff @(posedge clk)
    begin
        if (cmd.take)
        begin
            lo_reg  <= req.range_start;
            hi_reg  <= req.range_stop;
            key_reg <= req.search_value;
        end
        if (cmd.cap_lo)
        begin
            elo_reg <= rd_data_reg;
        end
        if (cmd.bound_step)
        begin
            ehi_reg <= rd_data_reg;
            mid_reg <= mid_first;
        end
        if (cmd.bisect_step)
        begin
            if (mid_gt)
            begin
                hi_reg  <= mid_reg;
                ehi_reg <= rd_data_reg;
            end
            else
            begin
                lo_reg  <= mid_reg;
                elo_reg <= rd_data_reg;
            end
            mid_reg <= mid_next;
        end
    end

    // Final end compare, high end wins
    assign hit_lo = elo_reg == key_reg;
    assign hit_hi = ehi_reg == key_reg;

    // Result register
    assign rsp_valid_next = cmd.res_we || (rsp_valid_reg && rsp_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.res_we)
        begin
            if (cmd.res_miss || !(hit_lo || hit_hi))
            begin
                rsp_reg.found       <= 1'b0;
                rsp_reg.match_index <= '0;
            end
            else
            begin
                rsp_reg.found       <= 1'b1;
                rsp_reg.match_index <= hit_hi ? hi_reg : lo_reg;
            end
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

`default_nettype wire

/* rtl/core/stbs_ctrl.sv */
// ----------------------------------------------------------------------------
// stbs_ctrl
// Sequencer of load and query transfers through the search steps.
// ----------------------------------------------------------------------------
`default_nettype none

module stbs_ctrl (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                req_valid,
    input  wire logic                req_kind,
    output logic                     req_stall,
    input  wire stbs_pkg::stbs_sts_t sts,
    output stbs_pkg::stbs_cmd_t      cmd
);
    import stbs_pkg::*;

    stbs_state_e state_reg, state_next;
    logic        take;

    assign req_stall = state_reg != S_IDLE;
    assign take      = req_valid && !req_stall;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and commands
    always_comb
    begin
        state_next      = state_reg;
        cmd.take        = 1'b0;
        cmd.addr_sel    = ADDR_LO;
        cmd.cap_lo      = 1'b0;
        cmd.bound_step  = 1'b0;
        cmd.bisect_step = 1'b0;
        cmd.res_we      = 1'b0;
        cmd.res_miss    = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                cmd.take = take;
                if (take && (req_kind == KIND_QUERY))
                begin
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                // read low end entry
                cmd.addr_sel = ADDR_LO;
                state_next   = sts.range_ok ? S_RD_HI : S_MISS;
            end
            S_RD_HI:
            begin
                cmd.addr_sel = ADDR_HI;
                cmd.cap_lo   = 1'b1;
                state_next   = S_BOUND;
            end
            S_BOUND:
            begin
                cmd.addr_sel   = ADDR_MID_FIRST;
                cmd.bound_step = 1'b1;
                if (!sts.bound_ok)
                begin
                    state_next = S_MISS;
                end
                else if (sts.wide)
                begin
                    state_next = S_BISECT;
                end
                else
                begin
                    state_next = S_FINISH;
                end
            end
            S_BISECT:
            begin
                // one halving per cycle, next mid read issued at once
                cmd.addr_sel    = ADDR_MID_NEXT;
                cmd.bisect_step = 1'b1;
                state_next      = sts.cont ? S_BISECT : S_FINISH;
            end
            S_FINISH:
            begin
                if (sts.res_free)
                begin
                    cmd.res_we = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_MISS:
            begin
                if (sts.res_free)
                begin
                    cmd.res_we   = 1'b1;
                    cmd.res_miss = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

/* rtl/core/sorted_table_binary_search.sv */
// Load transfer: written into the table at the accept edge; no result.
// Query transfer: range check, low end read, high end read and bound test, bisection with
// one table read per halving on a one-write, one-read registered table, then result load.
// Reversed range or value outside the end entries: miss; a held older result adds its stall.
// One query in flight; next transfer in the cycle after the result loads, even if it waits.
// Reset (rst_n, async, active low) clears control only; table contents stay undefined.
// ----------------------------------------------------------------------------
// sorted_table_binary_search
// Exact-match bisection over a sub-range of a sorted coordinate table.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_table_binary_search (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                req_valid,
    output logic                     req_stall,
    input  wire stbs_pkg::stbs_req_t req,
    output logic                     rsp_valid,
    input  wire logic                rsp_stall,
    output stbs_pkg::stbs_rsp_t      rsp
);
    import stbs_pkg::*;

    stbs_cmd_t cmd;
    stbs_sts_t sts;

    // Sequencer
    stbs_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_kind  (req.kind),
        .req_stall (req_stall),
        .sts       (sts),
        .cmd       (cmd)
    );

    // Table and search datapath
    stbs_dpath u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .cmd       (cmd),
        .sts       (sts),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

endmodule

`default_nettype wire

/* rtl/core/stbs_checker.sv */
// ----------------------------------------------------------------------------
// stbs_checker
// Port-level assertions for the search block, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "sorted_table_binary_search_defines.svh"

module stbs_checker (
    input wire logic                clk,
    input wire logic                rst_n,
    input wire logic                req_valid,
    input wire logic                req_stall,
    input wire stbs_pkg::stbs_req_t req,
    input wire logic                rsp_valid,
    input wire logic                rsp_stall,
    input wire stbs_pkg::stbs_rsp_t rsp
);
    import stbs_pkg::*;

    logic query_take;
    logic load_take;

    // Accepted request transfers by kind
    assign query_take = req_valid && !req_stall && (req.kind == KIND_QUERY);
    assign load_take  = req_valid && !req_stall && (req.kind == KIND_LOAD);

    // Stalled result holds
    `STBS_ASSERT_NEXT(a_rsp_hold, clk, rst_n, rsp_valid && rsp_stall, rsp_valid && $stable(rsp))

    // Miss reports index zero
    `STBS_ASSERT_NOW(a_miss_zero, clk, rst_n, rsp_valid && !rsp.found, rsp.match_index == '0)

    // A query transfer keeps the input side busy
    `STBS_ASSERT_NEXT(a_query_busy, clk, rst_n, query_take, req_stall)

    // A load never produces a result
    `STBS_ASSERT_NEXT(a_load_quiet, clk, rst_n, load_take && !rsp_valid, !rsp_valid)

endmodule

bind sorted_table_binary_search stbs_checker u_stbs_checker (.*);

`default_nettype wire

/* tb/sorted_table_binary_search_checker.sv */
// ----------------------------------------------------------------------------
// sorted_table_binary_search_checker
// Watches both channels of the search block. Every load transfer updates a
// local copy of the coordinate table. Every query transfer is answered right
// away by a local bisection, and the answer is queued. Each result transfer
// is compared field by field with the oldest queued answer.
// ----------------------------------------------------------------------------
module sorted_table_binary_search_checker (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    input  logic                req_stall,
    input  stbs_pkg::stbs_req_t req,
    input  logic                rsp_valid,
    input  logic                rsp_stall,
    input  stbs_pkg::stbs_rsp_t rsp,
    output int                  fail_count,
    output int                  pending
);
    import stbs_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    logic signed [COORD_W-1:0] coord_mem [TABLE_DEPTH];
    stbs_rsp_t                 answers_due[$];
    int                        n_fail = 0;
    int                        n_due  = 0;

    assign fail_count = n_fail;
    assign pending    = n_due;

    // Exact-match bisection over coord_mem[start..stop]
    function automatic stbs_rsp_t search_table(input stbs_req_t q);
        stbs_rsp_t                 r;
        int unsigned               lo;
        int unsigned               hi;
        int unsigned               mid;
        logic signed [COORD_W-1:0] key;
        r   = '0;
        key = q.search_value;
        lo  = q.range_start;
        hi  = q.range_stop;
        // out-of-ends values and bad ranges miss without bisection
        if (hi >= lo && hi < TABLE_DEPTH && key >= coord_mem[lo] && key <= coord_mem[hi])
        begin
            while (hi - lo > 1)
            begin
                mid = lo + (hi - lo) / 2;
                if (coord_mem[mid] > key)
                    hi = mid;
                else
                    lo = mid;
            end
            if (coord_mem[lo] == key)
            begin
                r.found       = 1'b1;
                r.match_index = IDX_W'(lo);
            end
            // high end wins when both ends match
            if (coord_mem[hi] == key)
            begin
                r.found       = 1'b1;
                r.match_index = IDX_W'(hi);
            end
        end
        return r;
    endfunction

    // Track accepted transfers on both channels
    always @(posedge clk)
    begin
        stbs_rsp_t want;
        if (rst_n)
        begin
            // request side first, so a same-edge result still sees older answers in front
            if (req_valid && !req_stall)
            begin
                if (req.kind == KIND_LOAD)
                begin
                    if (int'(req.write_index) < TABLE_DEPTH)
                        coord_mem[req.write_index] = req.entry_coord;
                end
                else
                    answers_due.push_back(search_table(req));
            end
            if (rsp_valid && !rsp_stall)
            begin
                if (answers_due.size() == 0)
                begin
                    $error("unexpected result transfer: found %0d match_index %0d",
                           rsp.found, rsp.match_index);
                    n_fail++;
                end
                else
                begin
                    want = answers_due.pop_front();
                    if (rsp.found !== want.found)
                    begin
                        $error("found: expected %0d, actual %0d", want.found, rsp.found);
                        n_fail++;
                    end
                    if (rsp.match_index !== want.match_index)
                    begin
                        $error("match_index: expected %0d, actual %0d",
                               want.match_index, rsp.match_index);
                        n_fail++;
                    end
                end
            end
            n_due = answers_due.size();
        end
    end

endmodule

/* tb/sorted_table_binary_search_tb.sv */
// ----------------------------------------------------------------------------
// sorted_table_binary_search_tb
// Drives load and query transfers into the search block: a directed opening
// over the field extremes and corner cases, then sorted runs of random
// content queried many times, with some order-breaking writes. Both sides
// idle at random in two phases, then run without idling; once the result side holds off
// long enough to back the block up. The checker beside the block gives the failure count.
// ----------------------------------------------------------------------------
module sorted_table_binary_search_tb;
    import stbs_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic signed [COORD_W-1:0] C_MIN = 32'sh8000_0000;
    localparam logic signed [COORD_W-1:0] C_MAX = 32'sh7FFF_FFFF;

    localparam int ITEM_TOTAL   = 630;
    localparam int PHASE_LEN    = 225;
    localparam int HOLD_AT      = 520;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 32;
    // room for ~700 transfers with stalls, gaps and the hold-off, several times over
    localparam int RUN_LIMIT_NS = 5_000_000;

    logic      clk;
    logic      rst_n;
    logic      req_valid;
    logic      req_stall;
    stbs_req_t req;
    logic      rsp_valid;
    logic      rsp_stall;
    stbs_rsp_t rsp;
    int        fail_count;
    int        pending;

    // Stimulus-side view of the table, used to build sorted runs and hits
    logic signed [COORD_W-1:0] shadow [TABLE_DEPTH];

    int sent_count    = 0;
    int send_idle_pct = 16;
    int recv_idle_pct = 57;
    int hold_left     = 0;
    bit hold_done     = 1'b0;

    sorted_table_binary_search i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    sorted_table_binary_search_checker i_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req_valid),
        .req_stall  (req_stall),
        .req        (req),
        .rsp_valid  (rsp_valid),
        .rsp_stall  (rsp_stall),
        .rsp        (rsp),
        .fail_count (fail_count),
        .pending    (pending)
    );

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Run limit
    initial
    begin
        #(RUN_LIMIT_NS);
        $display("RESULT: ERROR");
        $finish;
    end

    // Result side: random stall, plus one long hold-off to back the block up
    initial
    begin
        rsp_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_left > 0)
            begin
                hold_left--;
                rsp_stall <= 1'b1;
            end
            else if (!hold_done && sent_count >= HOLD_AT)
            begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
                rsp_stall <= 1'b1;
            end
            else
                rsp_stall <= ($urandom_range(99, 0) < recv_idle_pct);
        end
    end

    // One request transfer, with random idle cycles ahead of it
    task automatic drive_item(input stbs_req_t it);
        while ($urandom_range(99, 0) < send_idle_pct)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req       <= it;
        req_valid <= 1'b1;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        sent_count++;
        // idling phases
        if (sent_count >= 2 * PHASE_LEN)
        begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
        end
        else if (sent_count >= PHASE_LEN)
        begin
            send_idle_pct = 57;
            recv_idle_pct = 16;
        end
    endtask

    // Load transfer; unused query fields carry noise
    task automatic put_entry(input int idx, input logic signed [COORD_W-1:0] val);
        stbs_req_t it;
        it.kind         = KIND_LOAD;
        it.write_index  = IDX_W'(idx);
        it.entry_coord  = val;
        it.search_value = $urandom;
        it.range_start  = IDX_W'($urandom);
        it.range_stop   = IDX_W'($urandom);
        shadow[idx]     = val;
        drive_item(it);
    endtask

    // Query transfer; unused load fields carry noise
    task automatic ask(input int first, input int last, input logic signed [COORD_W-1:0] val);
        stbs_req_t it;
        it.kind         = KIND_QUERY;
        it.write_index  = IDX_W'($urandom);
        it.entry_coord  = $urandom;
        it.search_value = val;
        it.range_start  = IDX_W'(first);
        it.range_stop   = IDX_W'(last);
        drive_item(it);
    endtask

    // Write an ascending run at base; small steps give runs of duplicates
    task automatic fill_run(input int base, input int len);
        longint      acc;
        int unsigned step_max;
        case ($urandom_range(3, 0))
            0:       step_max = 2;
            1:       step_max = 1000;
            default: step_max = 32'h0100_0000;
        endcase
        if ($urandom_range(7, 0) == 0)
            acc = C_MIN;
        else
            acc = longint'(int'($urandom)) / 2;
        for (int i = 0; i < len; i++)
        begin
            put_entry(base + i, acc[COORD_W-1:0]);
            acc = acc + longint'($urandom_range(step_max, 0));
            if (acc > C_MAX)
                acc = C_MAX;
        end
    endtask

    // One query inside a written run: mostly hits, some near misses and outliers
    task automatic probe_run(input int base, input int len);
        int                        s;
        int                        e;
        int                        pick;
        logic signed [COORD_W-1:0] v;
        if ($urandom_range(1, 0) == 0)
        begin
            s = base;
            e = base + len - 1;
        end
        else
        begin
            s = base + $urandom_range(len - 1, 0);
            e = s + $urandom_range(base + len - 1 - s, 0);
        end
        pick = $urandom_range(99, 0);
        if (pick < 55)
            v = shadow[$urandom_range(e, s)];
        else if (pick < 70)
            v = shadow[$urandom_range(e, s)] + (($urandom_range(1, 0) == 0) ? 1 : -1);
        else if (pick < 80)
            v = shadow[s] - 1;
        else if (pick < 88)
            v = shadow[e] + 1;
        else
            v = $urandom;
        // reversed range now and then
        if (pick >= 94 && e > s)
            ask(e, s, v);
        else
            ask(s, e, v);
    endtask

    // Main stimulus
    initial
    begin
        int len;
        int base;
        bit first_run;

        rst_n     <= 1'b0;
        req_valid <= 1'b0;
        req       <= '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: field extremes, end hits, misses, reversed and single-entry ranges
        put_entry(0, C_MIN);
        put_entry(1, -5);
        put_entry(2, 0);
        put_entry(3, 7);
        put_entry(4, C_MAX);
        put_entry(1023, 100);
        put_entry(1022, 50);
        ask(0, 4, C_MIN);
        ask(0, 4, C_MAX);
        ask(0, 4, 7);
        ask(0, 4, 1);
        ask(1, 3, -6);
        ask(1, 3, 8);
        ask(3, 1, 0);
        ask(1023, 1023, 100);
        ask(1022, 1023, 50);
        // equal entries at both ends: high end wins
        put_entry(1023, 50);
        ask(1022, 1023, 50);
        put_entry(2, -5);
        ask(0, 4, -5);
        // unsorted range
        put_entry(3, -100);
        ask(0, 4, -100);
        ask(0, 4, C_MAX);

        // random: sorted runs, each queried several times
        first_run = 1'b1;
        while (sent_count < ITEM_TOTAL)
        begin
            if (first_run)
                len = $urandom_range(200, 140);
            else if ($urandom_range(4, 0) == 0)
                len = $urandom_range(64, 25);
            else
                len = $urandom_range(24, 1);
            first_run = 1'b0;
            base = $urandom_range(TABLE_DEPTH - len, 0);
            fill_run(base, len);
            // break the order inside the run
            if ($urandom_range(7, 0) == 0)
                put_entry(base + $urandom_range(len - 1, 0), $urandom);
            repeat ($urandom_range(12, 3)) probe_run(base, len);
            // stray write anywhere
            if ($urandom_range(9, 0) == 0)
                put_entry($urandom_range(TABLE_DEPTH - 1, 0), $urandom);
        end

        // drain; one edge first so the checker has queued the last transfer
        req_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fail_count == 0 && pending == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
